// ===== hdl/deq_pkg.sv =====
// Shared constants and types for the double-ended queue with search.
// Operation codes, status codes, field widths and the per-cell command.
// No dependencies.
`default_nettype none

package deq_pkg;

  // Fixed widths of the request and response fields
  localparam int MODE_W   = 3;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 4;
  localparam int CNT_W    = 5;
  localparam int STATUS_W = 2;

  // Operation codes carried in the request mode field
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CONTAINS   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_READ_AT    = 3'd5;

  // Status codes reported with every response
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd3;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_RIGHT,
    CELL_APPEND,
    CELL_SHIFT_LEFT,
    CELL_DROP_LAST
  } cell_op_e;

endpackage

`default_nettype wire

// ===== hdl/deq_if.sv =====
// Request and response channel interfaces of the deque.
// Valid/ready handshake with the payload; depends on deq_pkg.
`default_nettype none

interface deq_req_if;
  logic                         valid;
  logic                         ready;
  logic [deq_pkg::MODE_W-1:0]   mode;
  logic [deq_pkg::VAL_W-1:0]    value;
  logic [deq_pkg::POS_W-1:0]    position;

  modport source (output valid, mode, value, position, input ready);
  modport sink   (input valid, mode, value, position, output ready);
endinterface

interface deq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [deq_pkg::VAL_W-1:0]    read_value;
  logic [deq_pkg::VAL_W-1:0]    front_value;
  logic [deq_pkg::VAL_W-1:0]    back_value;
  logic                         found;
  logic [deq_pkg::CNT_W-1:0]    entry_count;
  logic [deq_pkg::STATUS_W-1:0] status;

  modport source (output valid, read_value, front_value, back_value, found, entry_count,
                  status, input ready);
  modport sink   (input valid, read_value, front_value, back_value, found, entry_count,
                  status, output ready);
endinterface

`default_nettype wire

// ===== hdl/deq_cell.sv =====
// One storage cell of the deque chain: a data word and an occupancy bit.
// Takes data from either neighbor on shifts; depends on deq_pkg.
`default_nettype none

module deq_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  deq_pkg::cell_op_e           op_i,
  input  logic [DATA_WIDTH-1:0]       push_data_i,
  input  logic [DATA_WIDTH-1:0]       key_i,
  input  logic [deq_pkg::POS_W-1:0]   pos_i,
  input  logic                        left_valid_i,
  input  logic [DATA_WIDTH-1:0]       left_data_i,
  input  logic                        right_valid_i,
  input  logic [DATA_WIDTH-1:0]       right_data_i,
  output logic                        valid_o,
  output logic [DATA_WIDTH-1:0]       data_o,
  output logic                        last_o,
  output logic                        hit_o,
  output logic                        pos_hit_o
);
  import deq_pkg::*;

  logic                  valid_q, valid_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;

  // Select next contents from the broadcast command and the neighbors
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    case (op_i)
      CELL_SHIFT_RIGHT: begin
        valid_d = left_valid_i;
        data_d  = left_data_i;
      end
      CELL_APPEND: begin
        // first empty cell takes the pushed word
        if (left_valid_i && !valid_q) begin
          valid_d = 1'b1;
          data_d  = push_data_i;
        end
      end
      CELL_SHIFT_LEFT: begin
        valid_d = right_valid_i;
        data_d  = right_data_i;
      end
      CELL_DROP_LAST: begin
        if (valid_q && !right_valid_i) begin
          valid_d = 1'b0;
        end
      end
      default: begin
        valid_d = valid_q;
        data_d  = data_q;
      end
    endcase
  end

  // Occupancy bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Data word
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Local status toward the reduction in the top level
  assign valid_o   = valid_q;
  assign data_o    = data_q;
  assign last_o    = valid_q && !right_valid_i;
  assign hit_o     = valid_q && (data_q == key_i);
  assign pos_hit_o = valid_q && (32'(pos_i) == 32'(IDX));

endmodule

`default_nettype wire

// ===== hdl/double_ended_queue_with_search.sv =====
// Double-ended queue with search: a row of DEPTH cells, front at cell 0.
// Path: a request updates the cells and the request stage registers, then loads the
// response register; a new request is held back until the previous one has loaded
// the response register, which waits while an unaccepted response is still held.
// Reset: occupancy bits, count and handshake state clear; queue starts empty.
// Depends on deq_pkg, deq_if and deq_cell.
`default_nettype none

module double_ended_queue_with_search #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  deq_req_if.sink         req_i,
  deq_rsp_if.source       rsp_o
);
  import deq_pkg::*;

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

  // Request stage state
  logic                  pend_q;
  logic [MODE_W-1:0]     mode_q;
  logic [DATA_WIDTH-1:0] key_q;
  logic [POS_W-1:0]      pos_q;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [CW-1:0]         count_q, count_d;
  cell_op_e              cell_op;

  // Response register
  logic                  rsp_valid_q;
  logic [VAL_W-1:0]      rd_q, front_q, back_q;
  logic                  found_q;
  logic [CNT_W-1:0]      cnt_out_q;
  logic [STATUS_W-1:0]   st_out_q;

  logic                  req_fire, rsp_load;
  logic [DATA_WIDTH-1:0] key_in;
  logic                  full, empty;

  // Chain taps
  logic [DEPTH-1:0]      valid_vec, last_vec, hit_vec, pos_vec;
  logic [DATA_WIDTH-1:0] data_w [DEPTH];

  assign req_fire = req_i.valid && req_i.ready;
  assign req_i.ready = !pend_q;
  assign rsp_load = pend_q && (!rsp_valid_q || rsp_o.ready);
  assign key_in   = DATA_WIDTH'(req_i.value);
  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);

  // Decode the request into a cell command, status and new count
  always_comb begin
    cell_op  = CELL_HOLD;
    status_d = ST_OK;
    count_d  = count_q;
    if (req_fire) begin
      case (req_i.mode)
        MODE_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cell_op = CELL_SHIFT_RIGHT;
            count_d = count_q + CW'(1);
          end
        end
        MODE_PUSH_BACK: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cell_op = CELL_APPEND;
            count_d = count_q + CW'(1);
          end
        end
        MODE_POP_FRONT: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            cell_op = CELL_SHIFT_LEFT;
            count_d = count_q - CW'(1);
          end
        end
        MODE_POP_BACK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            cell_op = CELL_DROP_LAST;
            count_d = count_q - CW'(1);
          end
        end
        MODE_READ_AT: begin
          if (CMP_W'(req_i.position) >= CMP_W'(count_q)) begin
            status_d = ST_BAD_POS;
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  lv, rv;
    logic [DATA_WIDTH-1:0] ld, rd;

    if (i == 0) begin : g_first
      assign lv = 1'b1;
      assign ld = key_in;
    end else begin : g_mid_l
      assign lv = valid_vec[i-1];
      assign ld = data_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_mid_r
      assign rv = valid_vec[i+1];
      assign rd = data_w[i+1];
    end

    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (cell_op),
      .push_data_i   (key_in),
      .key_i         (key_q),
      .pos_i         (pos_q),
      .left_valid_i  (lv),
      .left_data_i   (ld),
      .right_valid_i (rv),
      .right_data_i  (rd),
      .valid_o       (valid_vec[i]),
      .data_o        (data_w[i]),
      .last_o        (last_vec[i]),
      .hit_o         (hit_vec[i]),
      .pos_hit_o     (pos_vec[i])
    );
  end

  // Gather the front entry, the back entry and the addressed entry from the row
  logic [DATA_WIDTH-1:0] back_sel, pos_sel, front_sel;

  always_comb begin
    back_sel = '0;
    pos_sel  = '0;
    for (int k = 0; k < DEPTH; k++) begin
      back_sel = back_sel | (data_w[k] & {DATA_WIDTH{last_vec[k]}});
      pos_sel  = pos_sel  | (data_w[k] & {DATA_WIDTH{pos_vec[k]}});
    end
    front_sel = valid_vec[0] ? data_w[0] : '0;
  end

  // Request stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (req_fire) begin
        pend_q <= 1'b1;
      end else if (rsp_load) begin
        pend_q <= 1'b0;
      end
    end
  end

  // Hold the request fields for the result stage
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      mode_q   <= req_i.mode;
      key_q    <= key_in;
      pos_q    <= req_i.position;
      status_q <= status_d;
    end
  end

  // Response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rd_q      <= (mode_q == MODE_READ_AT) ? VAL_W'(pos_sel) : '0;
      front_q   <= VAL_W'(front_sel);
      back_q    <= VAL_W'(back_sel);
      found_q   <= (mode_q == MODE_CONTAINS) && (|hit_vec);
      cnt_out_q <= CNT_W'(count_q);
      st_out_q  <= status_q;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.read_value  = rd_q;
  assign rsp_o.front_value = front_q;
  assign rsp_o.back_value  = back_q;
  assign rsp_o.found       = found_q;
  assign rsp_o.entry_count = cnt_out_q;
  assign rsp_o.status      = st_out_q;

  // Occupancy bits of the row agree with the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("cell occupancy disagrees with count");

  // At most one cell of the row is marked as the back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(last_vec))
    else $error("more than one cell marked as back");

  // An accepted request always enters the result stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> pend_q)
    else $error("accepted request lost");

  // A push is only dropped when the row is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && !full && (req_i.mode == MODE_PUSH_FRONT || req_i.mode == MODE_PUSH_BACK))
      |=> (status_q != ST_FULL))
    else $error("push dropped while space left");

endmodule

`default_nettype wire
